// File: src/iqpdt_pkg.sv
// Shared constants and tables for the I/Q phase distance tracker.
`timescale 1ns / 1ps

package iqpdt_pkg;

  // Input sample and result field widths
  localparam int unsigned SampleW   = 32;
  localparam int unsigned PhaseW    = 16;
  localparam int unsigned StepW     = 17;
  localparam int unsigned DistW     = 40;
  localparam int unsigned HalfWaveW = 24;

  // Packed stream widths (tdata rounded up to whole bytes)
  localparam int unsigned InDataW  = 2 * SampleW;
  localparam int unsigned OutFieldW = PhaseW + StepW + DistW;
  localparam int unsigned OutDataW = ((OutFieldW + 7) / 8) * 8;

  // CORDIC datapath: 32-bit angle, x/y wide enough for the CORDIC gain
  localparam int unsigned AngW      = 32;
  localparam int unsigned CordXW    = 36;
  localparam int unsigned AtanLen   = 24;
  localparam int unsigned CordicStepsDefault = 16;

  // Reset value of the half wavelength register (Q8.16 cm)
  localparam logic [HalfWaveW-1:0] HalfWaveReset = 24'd64229;

  // atan(2^-k) as a 32-bit binary angle, one full turn is 2^32
  localparam logic [AngW-1:0] AtanTable [AtanLen] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10680862,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41721,     32'd20860,
    32'd10430,     32'd5215,      32'd2607,      32'd1303,
    32'd651,       32'd325,       32'd162,       32'd81
  };

endpackage

// File: src/iqpdt_cordic.sv
// Pipelined vectoring CORDIC: one rotation per stage, phase out as a 16-bit binary angle.
`timescale 1ns / 1ps

module iqpdt_cordic import iqpdt_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = CordicStepsDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [SampleW-1:0] i_sample_i,
  input  logic signed [SampleW-1:0] q_sample_i,
  output logic                      res_valid_o,
  input  logic                      res_ready_i,
  output logic [PhaseW-1:0]         phase_o
);

  // Rotations beyond the table length add nothing
  localparam int unsigned NumIter = (CORDIC_STEPS > AtanLen) ? AtanLen : CORDIC_STEPS;

  typedef struct packed {
    logic signed [CordXW-1:0] x;
    logic signed [CordXW-1:0] y;
    logic [AngW-1:0]          ang;
    logic                     zero;
  } stage_t;

  stage_t stg_q [NumIter+1];
  logic   vld_q [NumIter+1];
  logic   rdy   [NumIter+1];

  stage_t pre;
  logic [AngW-1:0] ang_rnd;

  // Half-turn pre-rotation for the left half-plane
  always_comb begin
    pre.zero = (i_sample_i == '0) && (q_sample_i == '0);
    if (i_sample_i[SampleW-1]) begin
      pre.x   = -CordXW'(i_sample_i);
      pre.y   = -CordXW'(q_sample_i);
      pre.ang = {1'b1, {(AngW-1){1'b0}}};
    end else begin
      pre.x   = CordXW'(i_sample_i);
      pre.y   = CordXW'(q_sample_i);
      pre.ang = '0;
    end
  end

  // Stall chain: a stage takes new data when empty or when it drains
  assign rdy[NumIter] = !vld_q[NumIter] || res_ready_i;
  assign in_ready_o   = rdy[0];

  // Entry stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (rdy[0]) begin
      vld_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_valid_i) begin
      stg_q[0] <= pre;
    end
  end

  // One micro-rotation per stage
  for (genvar k = 0; k < NumIter; k++) begin : g_iter
    stage_t nxt;

    assign rdy[k] = !vld_q[k] || rdy[k+1];

    always_comb begin
      nxt = stg_q[k];
      if (!stg_q[k].y[CordXW-1]) begin
        nxt.x   = stg_q[k].x + (stg_q[k].y >>> k);
        nxt.y   = stg_q[k].y - (stg_q[k].x >>> k);
        nxt.ang = stg_q[k].ang + AtanTable[k];
      end else begin
        nxt.x   = stg_q[k].x - (stg_q[k].y >>> k);
        nxt.y   = stg_q[k].y + (stg_q[k].x >>> k);
        nxt.ang = stg_q[k].ang - AtanTable[k];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (rdy[k+1]) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k+1] && vld_q[k]) begin
        stg_q[k+1] <= nxt;
      end
    end
  end

  // Round the 32-bit angle to 16 bits; zero vector reads as zero
  assign ang_rnd     = stg_q[NumIter].ang + AngW'(32'h8000);
  assign phase_o     = stg_q[NumIter].zero ? '0 : ang_rnd[AngW-1 -: PhaseW];
  assign res_valid_o = vld_q[NumIter];

endmodule

// File: src/iq_phase_distance_tracker.sv
// Top level: I/Q phase measurement, phase unwrap and saturating distance accumulator.
`timescale 1ns / 1ps

// Takes one I/Q sample per item and returns one result per item: the atan2 phase as a
// 16-bit binary angle, the unwrapped phase step from the previous item and the running
// distance in signed Q24.16 cm (saturating). One item is accepted every clock cycle
// unless back-pressure stalls the pipeline. The path has CORDIC_STEPS + 4 register stages
// (entry register, one pipelined CORDIC stage per rotation, unwrap, multiply and
// accumulate), with CORDIC_STEPS capped at 24. Each stage stalls only when full and
// blocked, so bubbles are squeezed out under back-pressure. half_wavelength is written
// through cfg_we_i/cfg_wdata_i and must only change while no items are in flight.
module iq_phase_distance_tracker import iqpdt_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = CordicStepsDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Input items
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [InDataW-1:0]    s_axis_tdata,   // [31:0] i_sample, [63:32] q_sample
  // Result items
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OutDataW-1:0]   m_axis_tdata,   // [15:0] phase_angle, [32:16] phase_step,
                                                // [72:33] distance, rest zero
  // Configuration
  input  logic                  cfg_we_i,
  input  logic [HalfWaveW-1:0]  cfg_wdata_i
);

  localparam int unsigned DiffW  = StepW + 1;
  localparam int unsigned ProdW  = StepW + HalfWaveW + 1;
  localparam int unsigned DeltaW = ProdW - 16;

  logic [HalfWaveW-1:0]     half_wave_q;

  logic                     cor_vld;
  logic                     cor_rdy;
  logic [PhaseW-1:0]        cor_phase;

  // Unwrap stage
  logic                     u_vld_q, u_rdy;
  logic [PhaseW-1:0]        u_phase_q, prev_phase_q;
  logic signed [StepW-1:0]  u_step_q, u_step_d;
  logic signed [DiffW-1:0]  diff;

  // Multiply stage
  logic                     p_vld_q, p_rdy;
  logic [PhaseW-1:0]        p_phase_q;
  logic signed [StepW-1:0]  p_step_q;
  logic signed [DeltaW-1:0] p_delta_q;
  logic signed [ProdW-1:0]  prod_rnd;

  // Output stage
  logic                     o_vld_q, o_rdy;
  logic [PhaseW-1:0]        o_phase_q;
  logic signed [StepW-1:0]  o_step_q;
  logic signed [DistW-1:0]  accum_q, accum_d;
  logic signed [DistW:0]    acc_sum;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_wave_q <= HalfWaveReset;
    end else if (cfg_we_i) begin
      half_wave_q <= cfg_wdata_i;
    end
  end

  // Phase measurement
  iqpdt_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .i_sample_i  (s_axis_tdata[SampleW-1:0]),
    .q_sample_i  (s_axis_tdata[InDataW-1:SampleW]),
    .res_valid_o (cor_vld),
    .res_ready_i (cor_rdy),
    .phase_o     (cor_phase)
  );

  // Stall chain for the back end
  assign o_rdy   = !o_vld_q || m_axis_tready;
  assign p_rdy   = !p_vld_q || o_rdy;
  assign u_rdy   = !u_vld_q || p_rdy;
  assign cor_rdy = u_rdy;

  // Unwrap: exactly +half turn maps to -32768, exactly -half turn to +32768
  always_comb begin
    diff = $signed({2'b00, cor_phase}) - $signed({2'b00, prev_phase_q});
    if (diff >= DiffW'(32768)) begin
      u_step_d = StepW'(diff - DiffW'(65536));
    end else if (diff <= -DiffW'(32768)) begin
      u_step_d = StepW'(diff + DiffW'(65536));
    end else begin
      u_step_d = StepW'(diff);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u_vld_q      <= 1'b0;
      prev_phase_q <= '0;
    end else if (u_rdy) begin
      u_vld_q <= cor_vld;
      if (cor_vld) begin
        prev_phase_q <= cor_phase;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (u_rdy && cor_vld) begin
      u_phase_q <= cor_phase;
      u_step_q  <= u_step_d;
    end
  end

  // Step times half wavelength, rounded to nearest (ties up) on the >> 16
  assign prod_rnd = (ProdW'(u_step_q) * $signed({1'b0, half_wave_q})) + ProdW'(32768);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
    end else if (p_rdy) begin
      p_vld_q <= u_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_rdy && u_vld_q) begin
      p_phase_q <= u_phase_q;
      p_step_q  <= u_step_q;
      p_delta_q <= prod_rnd[ProdW-1:16];
    end
  end

  // Saturating accumulate
  always_comb begin
    acc_sum = (DistW+1)'(accum_q) + (DistW+1)'(p_delta_q);
    if (acc_sum[DistW] != acc_sum[DistW-1]) begin
      accum_d = acc_sum[DistW] ? {1'b1, {(DistW-1){1'b0}}} : {1'b0, {(DistW-1){1'b1}}};
    end else begin
      accum_d = acc_sum[DistW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_vld_q <= 1'b0;
      accum_q <= '0;
    end else if (o_rdy) begin
      o_vld_q <= p_vld_q;
      if (p_vld_q) begin
        accum_q <= accum_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (o_rdy && p_vld_q) begin
      o_phase_q <= p_phase_q;
      o_step_q  <= p_step_q;
    end
  end

  assign m_axis_tvalid = o_vld_q;
  assign m_axis_tdata  = {(OutDataW-OutFieldW)'(0), accum_q, o_step_q, o_phase_q};

`ifndef ASSERT_OFF
  // Unwrapped step never leaves plus or minus half a turn
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    u_vld_q |-> (u_step_q <= StepW'(32768)) && (u_step_q >= -StepW'(32768)))
    else $error("phase step outside half a turn");

  // Distance only moves when an item enters the output register
  a_accum_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(o_rdy && p_vld_q) |=> $stable(accum_q))
    else $error("distance changed without an item");

  // A taken result with nothing behind it empties the output register
  a_out_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !p_vld_q) |=> !m_axis_tvalid)
    else $error("result repeated");
`endif

endmodule

// File: tb/sv/tb_iq_phase_distance_tracker.sv
// Self-checking testbench for the I/Q phase distance tracker.
`timescale 1ns / 1ps

import iqpdt_pkg::*;

typedef struct {
  logic        [PhaseW-1:0] phase;
  logic signed [StepW-1:0]  step;
  logic signed [DistW-1:0]  distance;
} ranging_result_t;

// Tracks phase and distance the way the block should, and checks each result item
class ranging_scoreboard;
  localparam int Steps = (CordicStepsDefault > AtanLen) ? AtanLen : CordicStepsDefault;
  localparam longint DistUpper = (64'sd1 <<< (DistW - 1)) - 1;
  localparam longint DistLower = -(64'sd1 <<< (DistW - 1));

  logic [HalfWaveW-1:0] half_wave;
  logic [PhaseW-1:0]    last_phase;
  longint               accum;
  ranging_result_t      expected_q[$];
  int                   errors;
  int                   checked;
  bit                   hit_upper;
  bit                   hit_lower;

  function new();
    half_wave  = HalfWaveReset;
    last_phase = '0;
    accum      = 0;
    errors     = 0;
    checked    = 0;
    hit_upper  = 0;
    hit_lower  = 0;
  endfunction

  function void set_half_wave(logic [HalfWaveW-1:0] hw);
    half_wave = hw;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  // Vectoring CORDIC, 64-bit x/y, floor shifts, 32-bit wrapping angle
  function logic [PhaseW-1:0] cordic_phase(logic signed [SampleW-1:0] i_v,
                                           logic signed [SampleW-1:0] q_v);
    longint      x;
    longint      y;
    longint      xs;
    longint      ys;
    logic [31:0] ang;
    if (i_v == 0 && q_v == 0) return '0;
    x   = i_v;
    y   = q_v;
    ang = '0;
    // left half plane: turn by half a turn first
    if (x < 0) begin
      x   = -x;
      y   = -y;
      ang = 32'h8000_0000;
    end
    for (int k = 0; k < Steps; k++) begin
      xs = x >>> k;
      ys = y >>> k;
      if (y >= 0) begin
        x   = x + ys;
        y   = y - xs;
        ang = ang + AtanTable[k];
      end else begin
        x   = x - ys;
        y   = y + xs;
        ang = ang - AtanTable[k];
      end
    end
    ang = ang + 32'h0000_8000;
    return ang[31:16];
  endfunction

  // One accepted sample: measure, unwrap, accumulate, queue the expected item
  function void note_sample(logic signed [SampleW-1:0] i_v, logic signed [SampleW-1:0] q_v);
    logic [PhaseW-1:0] now_phase;
    int                d;
    int                step;
    longint            prod;
    longint            acc;
    ranging_result_t   r;
    now_phase = cordic_phase(i_v, q_v);
    d = int'(now_phase) - int'(last_phase);
    if (d < 32768 && d > -32768) step = d;
    else if (d >= 32768) step = d - 65536;
    else step = d + 65536;
    // round to nearest, ties upward
    prod = longint'(step) * longint'(half_wave) + 64'sd32768;
    acc  = accum + (prod >>> 16);
    if (acc > DistUpper) begin
      acc       = DistUpper;
      hit_upper = 1;
    end
    if (acc < DistLower) begin
      acc       = DistLower;
      hit_lower = 1;
    end
    accum      = acc;
    last_phase = now_phase;
    r.phase    = now_phase;
    r.step     = step[StepW-1:0];
    r.distance = acc[DistW-1:0];
    expected_q.push_back(r);
  endfunction

  function void check_result(logic [OutDataW-1:0] tdata);
    ranging_result_t exp_r;
    if (expected_q.size() == 0) begin
      $error("result item with no sample pending: tdata %h", tdata);
      errors++;
      return;
    end
    exp_r = expected_q.pop_front();
    checked++;
    if (tdata[15:0] !== exp_r.phase) begin
      $error("phase_angle: expected %0d, actual %0d", exp_r.phase, tdata[15:0]);
      errors++;
    end
    if (tdata[32:16] !== exp_r.step) begin
      $error("phase_step: expected %0d, actual %0d", exp_r.step,
             $signed(tdata[32:16]));
      errors++;
    end
    if (tdata[72:33] !== exp_r.distance) begin
      $error("distance: expected %0d, actual %0d", exp_r.distance,
             $signed(tdata[72:33]));
      errors++;
    end
    if (tdata[OutDataW-1:73] !== '0) begin
      $error("padding: expected 0, actual %h", tdata[OutDataW-1:73]);
      errors++;
    end
  endfunction
endclass

module tb_iq_phase_distance_tracker;

  localparam longint CycleLimit = 2_000_000;
  localparam real    Pi         = 3.14159265358979;
  // half of full scale, for the half-turn and zero-crossing samples
  localparam int     RampA      = 1073741824;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [InDataW-1:0]   s_axis_tdata;   // [31:0] i_sample, [63:32] q_sample
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OutDataW-1:0]  m_axis_tdata;   // [15:0] phase_angle, [32:16] phase_step,
                                        // [72:33] distance, rest zero
  logic                 cfg_we_i;
  logic [HalfWaveW-1:0] cfg_wdata_i;

  ranging_scoreboard sb;
  int     idle_pct;
  int     stall_pct;
  int     hold_cycles;
  longint cycles;
  int     samples_sent;
  int     hw_writes;
  real    phasor_angle;

  iq_phase_distance_tracker dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // 2 ns clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Result side: random stalls, plus a long hold-off on request
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if (hold_cycles > 0) begin
        hold_cycles   = hold_cycles - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles = cycles + 1;
      if (cycles > CycleLimit) begin
        $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
        $display("FAIL iq_phase_distance_tracker");
        $finish;
      end
    end
  end

  // Offer one sample, with random idle cycles first; returns once accepted
  task automatic send_sample(input logic signed [SampleW-1:0] i_v,
                             input logic signed [SampleW-1:0] q_v);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {q_v, i_v};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_sample(i_v, q_v);
    samples_sent++;
  endtask

  // Stop offering and wait for every outstanding result item
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Register write while idle
  task automatic write_half_wave(input logic [HalfWaveW-1:0] hw);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= hw;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_half_wave(hw);
    hw_writes++;
  endtask

  // Mostly a rotating phasor of random amplitude, the rest raw and edge values
  task automatic run_random_phase(input int n, input int idle, input int stall,
                                  input logic [HalfWaveW-1:0] hw, input int hold,
                                  input bit pause_mid);
    logic signed [SampleW-1:0] i_v;
    logic signed [SampleW-1:0] q_v;
    real amp;
    int  kind;
    wait_drained();
    write_half_wave(hw);
    idle_pct    = idle;
    stall_pct   = stall;
    hold_cycles = hold;
    for (int n_i = 0; n_i < n; n_i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        // small steps usually, now and then a jump of up to half a turn
        if ($urandom_range(0, 9) == 0)
          phasor_angle += (real'($urandom_range(0, 2000)) - 1000.0) / 1000.0 * Pi;
        else
          phasor_angle += (real'($urandom_range(0, 2000)) - 1000.0) / 1000.0 * 0.6;
        if (phasor_angle > 2.0 * Pi) phasor_angle -= 2.0 * Pi;
        if (phasor_angle < -2.0 * Pi) phasor_angle += 2.0 * Pi;
        amp = real'(32'h7fff_ffff >> $urandom_range(0, 28));
        i_v = $rtoi(amp * $cos(phasor_angle));
        q_v = $rtoi(amp * $sin(phasor_angle));
      end else if (kind < 85) begin
        i_v = $urandom;
        q_v = $urandom;
      end else begin
        case ($urandom_range(0, 4))
          0: i_v = 32'sh7fff_ffff;
          1: i_v = 32'sh8000_0000;
          2: i_v = '0;
          3: i_v = -32'sd1;
          default: i_v = $signed($urandom_range(0, 8)) - 4;
        endcase
        case ($urandom_range(0, 4))
          0: q_v = 32'sh7fff_ffff;
          1: q_v = 32'sh8000_0000;
          2: q_v = '0;
          3: q_v = -32'sd1;
          default: q_v = $signed($urandom_range(0, 8)) - 4;
        endcase
      end
      send_sample(i_v, q_v);
      if (pause_mid && n_i == n / 2) wait_drained();
    end
  endtask

  // Stimulus
  initial begin
    sb            = new();
    idle_pct      = 0;
    stall_pct     = 0;
    hold_cycles   = 0;
    samples_sent  = 0;
    hw_writes     = 0;
    phasor_angle  = 0.0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset half wavelength, zero vector, field extremes, axes
    send_sample(32'sd0, 32'sd0);
    send_sample(32'sh7fff_ffff, 32'sd0);
    send_sample(32'sh8000_0000, 32'sd0);
    send_sample(32'sd0, 32'sh7fff_ffff);
    send_sample(32'sd0, 32'sh8000_0000);
    send_sample(32'sh7fff_ffff, 32'sh7fff_ffff);
    send_sample(32'sh8000_0000, 32'sh8000_0000);
    send_sample(32'sh8000_0000, 32'sh7fff_ffff);
    send_sample(32'sh7fff_ffff, 32'sh8000_0000);
    send_sample(-32'sd1, 32'sd0);
    send_sample(-32'sd1, -32'sd1);
    send_sample(32'sd1, 32'sd0);
    send_sample(32'sd0, -32'sd1);
    // exactly half a turn forward, then back
    send_sample(RampA, 32'sd0);
    send_sample(-RampA, 32'sd0);
    send_sample(RampA, 32'sd0);
    // crossing the zero angle both ways
    send_sample(RampA, 32'sd1048576);
    send_sample(RampA, -32'sd1048576);
    send_sample(RampA, 32'sd1048576);
    send_sample(32'sd0, 32'sd0);
    wait_drained();

    // Random phases under different idling and register settings
    run_random_phase(450, 0, 0, '0, 400, 0);
    run_random_phase(450, 62, 0, HalfWaveW'($urandom), 0, 0);
    run_random_phase(450, 0, 62, 24'd1, 0, 0);
    run_random_phase(450, 37, 37, HalfWaveW'($urandom), 0, 1);

    wait_drained();
    repeat (CordicStepsDefault + 12) @(posedge clk_i);
    $display("%0d samples sent, %0d results checked, %0d register writes",
             samples_sent, sb.checked, hw_writes);
    $display("distance clamp reached: upper %0d, lower %0d", sb.hit_upper, sb.hit_lower);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS iq_phase_distance_tracker");
    end else begin
      $display("FAIL iq_phase_distance_tracker");
    end
    $finish;
  end

endmodule
